[rtl/ps2h_pkg.sv]
`default_nettype none
package ps2h_pkg;

  // Request kinds carried in s_tuser
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Register reset values and register map
  localparam logic [15:0] INHIBIT_TICKS_RESET = 16'd100;
  localparam logic [15:0] RELEASE_TICKS_RESET = 16'd50;
  localparam logic        REG_INHIBIT         = 1'b0;
  localparam logic        REG_RELEASE         = 1'b1;

  // Transfer sequencer, one-hot
  typedef enum logic [17:0] {
    PH_IDLE    = 18'h00001,
    PH_INHIBIT = 18'h00002,
    PH_WB_LOW  = 18'h00004,
    PH_WB_HIGH = 18'h00008,
    PH_WP_LOW  = 18'h00010,
    PH_WP_HIGH = 18'h00020,
    PH_WS_LOW  = 18'h00040,
    PH_WS_HIGH = 18'h00080,
    PH_WA_LOW  = 18'h00100,
    PH_WA_HIGH = 18'h00200,
    PH_RS_LOW  = 18'h00400,
    PH_RS_HIGH = 18'h00800,
    PH_RB_LOW  = 18'h01000,
    PH_RB_HIGH = 18'h02000,
    PH_RP_LOW  = 18'h04000,
    PH_RP_HIGH = 18'h08000,
    PH_RT_LOW  = 18'h10000,
    PH_RELEASE = 18'h20000
  } phase_t;

  // One result item
  typedef struct packed {
    logic       was_write;
    logic       busy_res;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       data_drive_low;
    logic       clock_drive_low;
  } result_t;

endpackage
`default_nettype wire

[rtl/ps2_host_byte_transfer_unit.sv]
// Each result is registered when its sample tick or request is accepted.
// Throughput: one item per cycle while the skid entry is empty; a two-entry output
// register (main plus skid) takes one more item while the output side stalls.
// Reset: synchronous, active high; sequencer idle, both lines released,
// inhibit_ticks = 100, release_ticks = 50, output queue empty.
`default_nettype none
module ps2_host_byte_transfer_unit
  import ps2h_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // tx_byte[7:0], clock_line[8], data_line[9], zero[15:10]
  input  wire logic [1:0]  s_tuser,   // kind[1:0]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // clock_drive_low[0], data_drive_low[1], rx_byte[9:2],
                                      // rx_valid[10], busy_res[11], zero[15:12]
  output logic [0:0]       m_tuser,   // was_write[0]
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0] inhibit_ticks;
  logic [15:0] release_ticks;

  phase_t      phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic        parity_bit, parity_bit_next;
  logic [15:0] wait_count, wait_count_next;
  logic        in_write, in_write_next;
  logic        clock_hold, clock_hold_next;
  logic        data_hold, data_hold_next;

  result_t     res_next, res_main, res_skid;
  logic        main_valid, skid_valid;

  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic        clock_line, data_line;
  logic        accept;
  logic [3:0]  bit_count_inc;
  logic        cfg_write;

  assign kind       = s_tuser;
  assign tx_byte    = s_tdata[7:0];
  assign clock_line = s_tdata[8];
  assign data_line  = s_tdata[9];

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inhibit_ticks <= INHIBIT_TICKS_RESET;
      release_ticks <= RELEASE_TICKS_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_INHIBIT) begin
        inhibit_ticks <= pwdata[15:0];
      end else begin
        release_ticks <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_RELEASE) begin
      prdata = {16'd0, release_ticks};
    end else begin
      prdata = {16'd0, inhibit_ticks};
    end
  end

  assign bit_count_inc = bit_count + 4'd1;

  // Sequencer step for one tick
  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_byte_next = shift_byte;
    parity_bit_next = parity_bit;
    wait_count_next = wait_count;
    in_write_next   = in_write;
    clock_hold_next = clock_hold;
    data_hold_next  = data_hold;
    res_next        = '0;

    if (phase == PH_IDLE && kind == KIND_WRITE) begin
      shift_byte_next = tx_byte;
      bit_count_next  = 4'd0;
      parity_bit_next = 1'b1;
      in_write_next   = 1'b1;
      clock_hold_next = 1'b1;
      wait_count_next = inhibit_ticks;
      phase_next      = PH_INHIBIT;
    end else if (phase == PH_IDLE && kind == KIND_READ) begin
      in_write_next   = 1'b0;
      clock_hold_next = 1'b0;
      shift_byte_next = 8'd0;
      bit_count_next  = 4'd0;
      phase_next      = PH_RS_LOW;
    end else begin
      case (phase)
        PH_IDLE: begin
        end
        PH_INHIBIT: begin
          if (wait_count <= 16'd1) begin
            wait_count_next = 16'd0;
            data_hold_next  = 1'b1;
            clock_hold_next = 1'b0;
            phase_next      = PH_WB_LOW;
          end else begin
            wait_count_next = wait_count - 16'd1;
          end
        end
        PH_WB_LOW: begin
          if (!clock_line) begin
            data_hold_next  = ~shift_byte[0];
            parity_bit_next = parity_bit ^ shift_byte[0];
            phase_next      = PH_WB_HIGH;
          end
        end
        PH_WB_HIGH: begin
          if (clock_line) begin
            shift_byte_next = {1'b0, shift_byte[7:1]};
            bit_count_next  = bit_count_inc;
            phase_next      = bit_count_inc[3] ? PH_WP_LOW : PH_WB_LOW;
          end
        end
        PH_WP_LOW: begin
          if (!clock_line) begin
            data_hold_next = ~parity_bit;
            phase_next     = PH_WP_HIGH;
          end
        end
        PH_WP_HIGH: begin
          if (clock_line) phase_next = PH_WS_LOW;
        end
        PH_WS_LOW: begin
          if (!clock_line) begin
            data_hold_next = 1'b0;
            phase_next     = PH_WS_HIGH;
          end
        end
        PH_WS_HIGH: begin
          if (clock_line) phase_next = PH_WA_LOW;
        end
        PH_WA_LOW: begin
          if (!clock_line) phase_next = PH_WA_HIGH;
        end
        PH_WA_HIGH: begin
          // line-control bit seen: collect the acknowledge byte
          if (clock_line) begin
            clock_hold_next = 1'b0;
            shift_byte_next = 8'd0;
            bit_count_next  = 4'd0;
            phase_next      = PH_RS_LOW;
          end
        end
        PH_RS_LOW: begin
          if (!clock_line) phase_next = PH_RS_HIGH;
        end
        PH_RS_HIGH: begin
          if (clock_line) phase_next = PH_RB_LOW;
        end
        PH_RB_LOW: begin
          if (!clock_line) begin
            shift_byte_next[bit_count[2:0]] = shift_byte[bit_count[2:0]] | data_line;
            phase_next = PH_RB_HIGH;
          end
        end
        PH_RB_HIGH: begin
          if (clock_line) begin
            bit_count_next = bit_count_inc;
            phase_next     = bit_count_inc[3] ? PH_RP_LOW : PH_RB_LOW;
          end
        end
        PH_RP_LOW: begin
          if (!clock_line) phase_next = PH_RP_HIGH;
        end
        PH_RP_HIGH: begin
          if (clock_line) phase_next = PH_RT_LOW;
        end
        PH_RT_LOW: begin
          if (!clock_line) begin
            clock_hold_next = 1'b1;
            wait_count_next = release_ticks;
            phase_next      = PH_RELEASE;
          end
        end
        PH_RELEASE: begin
          if (wait_count <= 16'd1) begin
            wait_count_next    = 16'd0;
            res_next.rx_byte   = shift_byte;
            res_next.rx_valid  = 1'b1;
            res_next.was_write = in_write;
            in_write_next      = 1'b0;
            phase_next         = PH_IDLE;
          end else begin
            wait_count_next = wait_count - 16'd1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    res_next.clock_drive_low = clock_hold_next;
    res_next.data_drive_low  = data_hold_next;
    res_next.busy_res        = (phase_next != PH_IDLE);
  end

  // State advances once per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= 4'd0;
      shift_byte <= 8'd0;
      parity_bit <= 1'b1;
      wait_count <= 16'd0;
      in_write   <= 1'b0;
      clock_hold <= 1'b0;
      data_hold  <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_byte <= shift_byte_next;
      parity_bit <= parity_bit_next;
      wait_count <= wait_count_next;
      in_write   <= in_write_next;
      clock_hold <= clock_hold_next;
      data_hold  <= data_hold_next;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !main_valid) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !main_valid) begin
      if (skid_valid) begin
        res_main <= res_skid;
      end else if (accept) begin
        res_main <= res_next;
      end
    end else if (accept) begin
      res_skid <= res_next;
    end
  end

  assign m_tvalid = main_valid;
  assign m_tdata  = {4'd0, res_main.busy_res, res_main.rx_valid, res_main.rx_byte,
                     res_main.data_drive_low, res_main.clock_drive_low};
  assign m_tuser  = res_main.was_write;

endmodule
`default_nettype wire

[rtl/ps2h_checker.sv]
`default_nettype none
module ps2h_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [15:0] s_tdata,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [0:0]  m_tuser,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // a completed byte ends the transfer
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[10] |-> !m_tdata[11])
    else $error("busy set on completing tick");

  // no byte and no write flag without a completion
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[10] |-> m_tdata[9:2] == 8'd0 && !m_tuser[0])
    else $error("rx fields set without rx_valid");

  // reset empties the output queue
  assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("output queue not empty after reset");

endmodule

bind ps2_host_byte_transfer_unit ps2h_checker u_ps2h_checker (.*);
`default_nettype wire
